[sv/midi_clock_tempo_tracker_macros.svh]
// Assertion helpers shared by the tempo tracker modules.
`ifndef MIDI_CLOCK_TEMPO_TRACKER_MACROS_SVH
`define MIDI_CLOCK_TEMPO_TRACKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCTT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tempo tracker assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MCTT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tempo tracker assertion failed");

`endif

[sv/mctt_pkg.sv]
package mctt_pkg;

   // Field widths fixed by the stream format.
   localparam int GAP_W   = 16;
   localparam int STAMP_W = 32;
   localparam int TEMPO_W = 23;
   localparam int PULSE_W = 24;
   localparam int JUMP_W  = 10;
   localparam int TREND_W = 8;
   localparam int JIT_W   = 10;
   localparam int CSR_W   = 16;
   localparam int RSP_W   = 80;

   // Tempo in tenths of BPM is 25000 * count / sum of ms gaps (24 ticks per beat).
   localparam logic [14:0]        TEMPO_NUM = 15'd25000;
   localparam logic [TEMPO_W-1:0] TEMPO_MAX = 23'd5000000;

   // Register reset values.
   localparam logic [GAP_W-1:0]   MAX_GAP_RST = 16'd500;
   localparam logic [GAP_W-1:0]   MIN_GAP_RST = 16'd5;
   localparam logic [JUMP_W-1:0]  JUMP_RST    = 10'd10;
   localparam logic [TREND_W-1:0] TREND_RST   = 8'd24;

   typedef enum logic [1:0] {
      CSR_MAX_GAP = 2'd0,
      CSR_MIN_GAP = 2'd1,
      CSR_JUMP    = 2'd2,
      CSR_TREND   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_FIRST   = 3'd0,
      ST_ACCEPT  = 3'd1,
      ST_REWIND  = 3'd2,
      ST_LONG    = 3'd3,
      ST_SHORT   = 3'd4,
      ST_RESTART = 3'd5
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic classify;
      logic update;
      logic div_start;
      logic div_sel_tempo;
      logic pulse_latch;
      logic tempo_latch;
      logic tempo_sat;
      logic smooth;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      status_type code;
      logic       sum_zero;
      logic       div_busy;
      logic       div_done;
   } stat_type;

endpackage

[sv/mctt_div.sv]
`include "midi_clock_tempo_tracker_macros.svh"

module mctt_div import mctt_pkg::*; #(
   parameter int DW = 29,
   parameter int VW = 21
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          busy,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CW = $clog2(DW + 1);

   logic [CW-1:0] cnt_ff;
   logic          done_ff;
   logic [VW-1:0] rem_ff;
   logic [DW-1:0] quo_ff;
   logic [VW-1:0] dvs_ff;

   logic [VW:0]   shifted;
   logic [VW+1:0] trial;
   logic          ge;

   // One restoring step: bring down the next dividend bit and try the subtract.
   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dvs_ff};
   assign ge      = ~trial[VW+1];

   // Step counter and completion pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == CW'(1));
         if (start) begin
            cnt_ff <= CW'(DW);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
      end
   end

   // Remainder and quotient; the quotient shifts in over the dividend bits.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (cnt_ff != '0) begin
         rem_ff <= ge ? trial[VW-1:0] : shifted[VW-1:0];
         quo_ff <= {quo_ff[DW-2:0], ge};
      end
   end

   assign busy     = (cnt_ff != '0);
   assign done     = done_ff;
   assign quotient = quo_ff;

   `MCTT_ASSERT_NOW(a_done_after_last_step, clock, reset, done_ff, cnt_ff == '0)

endmodule

[sv/mctt_dp.sv]
`include "midi_clock_tempo_tracker_macros.svh"

module mctt_dp import mctt_pkg::*; #(
   parameter int WINDOW = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   // Input beat payload
   input  logic                 req_kind,
   input  logic [STAMP_W-1:0]   req_stamp,
   // Register writes
   input  logic                 csr_we,
   input  logic [1:0]           csr_addr,
   input  logic [CSR_W-1:0]     csr_wdata,
   // Controller link
   input  cmd_type              cmd,
   output stat_type             stat,
   // Result payload
   output logic [RSP_W-1:0]     rsp_data
);

   localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FW = $clog2(WINDOW + 1);
   localparam int SW = GAP_W + $clog2(WINDOW);
   localparam int NW = 15 + FW;
   localparam int DW = (SW + 8 > NW) ? SW + 8 : NW;

   // Configuration registers
   logic [GAP_W-1:0]   max_gap_ff;
   logic [GAP_W-1:0]   min_gap_ff;
   logic [JUMP_W-1:0]  jump_ff;
   logic [TREND_W-1:0] trend_ff;

   // Tracker state
   logic [STAMP_W-1:0]       last_ff;
   logic                     have_ff;
   logic [PW-1:0]            pos_ff;
   logic [FW-1:0]            fill_ff;
   logic [SW-1:0]            sum_ff;
   logic [PULSE_W-1:0]       pulse_ff;
   logic signed [JIT_W-1:0]  jitter_ff;
   logic [TEMPO_W-1:0]       smooth_ff;

   // Per-item payload
   logic                 kind_ff;
   logic [STAMP_W-1:0]   stamp_ff;
   logic [GAP_W-1:0]     gap_ff;
   status_type           status_ff;
   logic [TEMPO_W-1:0]   raw_ff;
   logic [GAP_W-1:0]     rd_ff;
   logic [RSP_W-1:0]     rsp_ff;

   logic [GAP_W-1:0]     ring_mem [WINDOW];

   // Classification of the captured beat.
   logic [STAMP_W-1:0] gap32;
   status_type         code;

   assign gap32 = stamp_ff - last_ff;

   always_comb begin
      priority if (kind_ff) begin
         code = ST_RESTART;
      end else if (!have_ff) begin
         code = ST_FIRST;
      end else if (stamp_ff < last_ff) begin
         code = ST_REWIND;
      end else if (gap32 > {16'd0, max_gap_ff}) begin
         code = ST_LONG;
      end else if (gap32 < {16'd0, min_gap_ff}) begin
         code = ST_SHORT;
      end else begin
         code = ST_ACCEPT;
      end
   end

   // While the window is filling, the slot under pos_ff was never written since the last clear.
   logic             ring_full;
   logic [GAP_W-1:0] old_gap;
   logic [SW-1:0]    sum_in;

   assign ring_full = (fill_ff == FW'(WINDOW));
   assign old_gap   = ring_full ? rd_ff : '0;
   assign sum_in    = sum_ff - SW'(old_gap) + SW'(gap_ff);

   // Divider operands: pulse width first, then tempo.
   logic [NW-1:0]  tempo_num;
   logic [DW-1:0]  div_dividend;
   logic [SW-1:0]  div_divisor;
   logic [DW-1:0]  div_quo;
   logic           div_busy;
   logic           div_done;

   assign tempo_num    = NW'(TEMPO_NUM) * NW'(fill_ff);
   assign div_dividend = cmd.div_sel_tempo ? DW'(tempo_num) : DW'({sum_ff, 8'd0});
   assign div_divisor  = cmd.div_sel_tempo ? sum_ff : SW'(fill_ff);

   mctt_div #(
      .DW (DW),
      .VW (SW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Smoothing step: jump on a large difference, otherwise count the trend.
   logic [TEMPO_W:0]         diff;
   logic [TEMPO_W:0]         diff_mag;
   logic                     diff_neg;
   logic                     diff_zero;
   logic [TEMPO_W-1:0]       absdiff;
   logic                     do_jump;
   logic signed [JIT_W-1:0]  jit_up;
   logic signed [JIT_W-1:0]  jit_dn;
   logic signed [JIT_W:0]    trend_s;
   logic                     step_up;
   logic                     step_dn;

   assign diff      = {1'b0, raw_ff} - {1'b0, smooth_ff};
   assign diff_neg  = diff[TEMPO_W];
   assign diff_zero = (diff == '0);
   assign diff_mag  = diff_neg ? ((TEMPO_W + 1)'(0) - diff) : diff;
   assign absdiff   = diff_mag[TEMPO_W-1:0];
   assign do_jump   = (absdiff > TEMPO_W'(jump_ff));
   assign jit_up    = jitter_ff + JIT_W'(1);
   assign jit_dn    = jitter_ff - JIT_W'(1);
   assign trend_s   = $signed({3'b000, trend_ff});
   assign step_up   = ($signed({jit_up[JIT_W-1], jit_up}) > trend_s);
   assign step_dn   = ($signed({jit_dn[JIT_W-1], jit_dn}) < ((JIT_W + 1)'(0) - trend_s));

   // Configuration and tracker state.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_gap_ff <= MAX_GAP_RST;
         min_gap_ff <= MIN_GAP_RST;
         jump_ff    <= JUMP_RST;
         trend_ff   <= TREND_RST;
         last_ff    <= '0;
         have_ff    <= 1'b0;
         pos_ff     <= '0;
         fill_ff    <= '0;
         sum_ff     <= '0;
         pulse_ff   <= '0;
         jitter_ff  <= '0;
         smooth_ff  <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_addr))
               CSR_MAX_GAP: max_gap_ff <= csr_wdata;
               CSR_MIN_GAP: min_gap_ff <= csr_wdata;
               CSR_JUMP:    jump_ff    <= csr_wdata[JUMP_W-1:0];
               CSR_TREND:   trend_ff   <= csr_wdata[TREND_W-1:0];
            endcase
         end

         if (cmd.classify) begin
            if (code == ST_RESTART) begin
               last_ff  <= '0;
               have_ff  <= 1'b0;
               pulse_ff <= '0;
            end else begin
               last_ff <= stamp_ff;
               have_ff <= 1'b1;
            end
            if (code == ST_RESTART || code == ST_REWIND || code == ST_LONG ||
                code == ST_SHORT) begin
               pos_ff    <= '0;
               fill_ff   <= '0;
               sum_ff    <= '0;
               jitter_ff <= '0;
            end
         end

         if (cmd.update) begin
            sum_ff <= sum_in;
            pos_ff <= (pos_ff == PW'(WINDOW - 1)) ? '0 : pos_ff + PW'(1);
            if (!ring_full) begin
               fill_ff <= fill_ff + FW'(1);
            end
         end

         if (cmd.pulse_latch) begin
            pulse_ff <= div_quo[PULSE_W-1:0];
         end

         if (cmd.smooth) begin
            priority if (do_jump) begin
               smooth_ff <= raw_ff;
               jitter_ff <= '0;
            end else if (!diff_zero && !diff_neg) begin
               if (step_up) begin
                  smooth_ff <= smooth_ff + TEMPO_W'(1);
                  jitter_ff <= '0;
               end else begin
                  jitter_ff <= jit_up;
               end
            end else if (diff_neg) begin
               if (step_dn) begin
                  smooth_ff <= smooth_ff - TEMPO_W'(1);
                  jitter_ff <= '0;
               end else begin
                  jitter_ff <= jit_dn;
               end
            end else if (jitter_ff > 0) begin
               jitter_ff <= jit_dn;
            end else if (jitter_ff < 0) begin
               jitter_ff <= jit_up;
            end else begin
               jitter_ff <= jitter_ff;
            end
         end
      end
   end

   // Per-item payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind;
         stamp_ff <= req_stamp;
      end
      if (cmd.classify) begin
         status_ff <= code;
         gap_ff    <= gap32[GAP_W-1:0];
         raw_ff    <= '0;
      end
      if (cmd.tempo_sat) begin
         raw_ff <= TEMPO_MAX;
      end else if (cmd.tempo_latch) begin
         raw_ff <= (div_quo > DW'(TEMPO_MAX)) ? TEMPO_MAX : div_quo[TEMPO_W-1:0];
      end
      if (cmd.load_out) begin
         rsp_ff <= {7'd0, smooth_ff, raw_ff, pulse_ff, status_ff};
      end
   end

   // Gap ring: one write and one registered read, both at pos_ff.
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         ring_mem[pos_ff] <= gap_ff;
      end
      rd_ff <= ring_mem[pos_ff];
   end

   assign stat.code     = code;
   assign stat.sum_zero = (sum_ff == '0);
   assign stat.div_busy = div_busy;
   assign stat.div_done = div_done;
   assign rsp_data      = rsp_ff;

   `MCTT_ASSERT_NOW(a_pos_tracks_fill, clock, reset, !ring_full, FW'(pos_ff) == fill_ff)
   `MCTT_ASSERT_NOW(a_empty_sum_zero, clock, reset, fill_ff == '0, sum_ff == '0)
   `MCTT_ASSERT_NOW(a_pulse_fits, clock, reset, cmd.pulse_latch, (div_quo >> PULSE_W) == '0)

endmodule

[sv/mctt_ctrl.sv]
`include "midi_clock_tempo_tracker_macros.svh"

module mctt_ctrl import mctt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLASSIFY,
      S_UPDATE,
      S_PULSE_START,
      S_PULSE_WAIT,
      S_TEMPO_START,
      S_TEMPO_WAIT,
      S_SMOOTH,
      S_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Command decode for the current step.
   always_comb begin
      cmd               = '0;
      cmd.capture       = (state_ff == S_IDLE) && req_tvalid;
      cmd.classify      = (state_ff == S_CLASSIFY);
      cmd.update        = (state_ff == S_UPDATE);
      cmd.div_start     = (state_ff == S_PULSE_START) ||
                          ((state_ff == S_TEMPO_START) && !stat.sum_zero);
      cmd.div_sel_tempo = (state_ff == S_TEMPO_START);
      cmd.pulse_latch   = (state_ff == S_PULSE_WAIT) && stat.div_done;
      cmd.tempo_latch   = (state_ff == S_TEMPO_WAIT) && stat.div_done;
      cmd.tempo_sat     = (state_ff == S_TEMPO_START) && stat.sum_zero;
      cmd.smooth        = (state_ff == S_SMOOTH);
      cmd.load_out      = (state_ff == S_DONE) && out_free;
   end

   // Sequencer and the result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= S_CLASSIFY;
               end
            end
            S_CLASSIFY: begin
               state_ff <= (stat.code == ST_ACCEPT) ? S_UPDATE : S_DONE;
            end
            S_UPDATE: begin
               state_ff <= S_PULSE_START;
            end
            S_PULSE_START: begin
               state_ff <= S_PULSE_WAIT;
            end
            S_PULSE_WAIT: begin
               if (stat.div_done) begin
                  state_ff <= S_TEMPO_START;
               end
            end
            S_TEMPO_START: begin
               state_ff <= stat.sum_zero ? S_SMOOTH : S_TEMPO_WAIT;
            end
            S_TEMPO_WAIT: begin
               if (stat.div_done) begin
                  state_ff <= S_SMOOTH;
               end
            end
            S_SMOOTH: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   `MCTT_ASSERT_NOW(a_idle_divider_quiet, clock, reset, state_ff == S_IDLE, !stat.div_busy)
   `MCTT_ASSERT_NEXT(a_divide_only_on_accept, clock, reset,
                     cmd.classify && stat.code != ST_ACCEPT, state_ff == S_DONE)

endmodule

[sv/midi_clock_tempo_tracker.sv]
// One beat in, one result out. Restart, first, rewind, long and short beats go from classify
// straight to the result register. An accepted gap also passes through the window update, a
// pulse width divide and a tempo divide (skipped when the gap sum is zero), both in one
// bit-serial divider of DW = 24 + log2(WINDOW) bits, then smoothing. A new beat is taken the
// cycle after the result is registered; a stalled result holds off the input.
// Synchronous active-high reset restores register defaults and clears all tracker state.
module midi_clock_tempo_tracker import mctt_pkg::*; #(
   parameter int WINDOW = 32
) (
   input  logic               clock,
   input  logic               reset,
   // Input stream
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [31:0]        req_tdata,   // [31:0] timestamp_ms
   input  logic               req_tuser,   // [0] kind
   // Register write port
   input  logic               csr_we,
   input  logic [1:0]         csr_addr,
   input  logic [CSR_W-1:0]   csr_wdata,
   // Result stream
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata    // [2:0] status, [26:3] pulse_width_q8,
                                           // [49:27] raw_tempo_x10,
                                           // [72:50] smooth_tempo_x10, [79:73] zero
);

   cmd_type  cmd;
   stat_type stat;

   mctt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mctt_dp #(
      .WINDOW (WINDOW)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_kind  (req_tuser),
      .req_stamp (req_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_tdata)
   );

endmodule

[test/tb_midi_clock_tempo_tracker.sv]
module tb_midi_clock_tempo_tracker;
   import mctt_pkg::*;

   localparam int WINDOW = 32;

   // One input beat: a clock tick with its stamp, or a restart request.
   typedef struct {
      logic        restart;
      logic [31:0] stamp;
   } tick_beat_type;

   // One tempo report as carried on the result stream.
   typedef struct {
      status_type         status;
      logic [PULSE_W-1:0] pulse;
      logic [TEMPO_W-1:0] raw;
      logic [TEMPO_W-1:0] smooth;
   } tempo_report_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [31:0]        req_tdata = '0;
   logic               req_tuser = 1'b0;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_addr = '0;
   logic [CSR_W-1:0]   csr_wdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;

   midi_clock_tempo_tracker #(
      .WINDOW(WINDOW)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Register copies held by the predictor.
   logic [GAP_W-1:0]   cfg_max_gap;
   logic [GAP_W-1:0]   cfg_min_gap;
   logic [JUMP_W-1:0]  cfg_jump;
   logic [TREND_W-1:0] cfg_trend;

   // Tracker state held by the predictor.
   logic [31:0]        trk_last_stamp;
   logic               trk_have_last;
   logic [GAP_W-1:0]   trk_ring [WINDOW];
   int                 trk_pos;
   int unsigned        trk_sum;
   int unsigned        trk_fill;
   logic [PULSE_W-1:0] trk_pulse;
   int                 trk_jitter;
   logic [TEMPO_W-1:0] trk_smooth;

   tick_beat_type    beats_to_send [$];
   tempo_report_type reports_due [$];
   bit               failed = 1'b0;

   // Stimulus generator state.
   logic [31:0] gen_stamp = '0;
   int          base_gap = 20;
   int          run_left = 0;

   // Sender and receiver pacing.
   int          burst_left = 0;
   int          pause_left = 0;
   int          ready_mode = 0;
   int          mode_left = 0;
   logic [2:0]  stall_phase = '0;

   function automatic void clear_gap_window();
      foreach (trk_ring[i]) trk_ring[i] = '0;
      trk_pos = 0;
      trk_sum = 0;
      trk_fill = 0;
      trk_jitter = 0;
   endfunction

   function automatic void restart_tracker_state();
      trk_last_stamp = '0;
      trk_have_last = 1'b0;
      trk_pulse = '0;
      clear_gap_window();
   endfunction

   function automatic void reset_tracker_model();
      cfg_max_gap = MAX_GAP_RST;
      cfg_min_gap = MIN_GAP_RST;
      cfg_jump = JUMP_RST;
      cfg_trend = TREND_RST;
      restart_tracker_state();
      trk_smooth = '0;
   endfunction

   // Push one accepted gap into the window, update the pulse width and smoothed tempo, and return the raw tempo.
   function automatic logic [TEMPO_W-1:0] take_gap(logic [GAP_W-1:0] gap);
      longint unsigned     q;
      logic [TEMPO_W-1:0]  raw;
      logic [TEMPO_W-1:0]  next_tempo;
      int                  diff;
      int unsigned         absdiff;
      trk_sum = trk_sum - 32'(trk_ring[trk_pos]) + 32'(gap);
      trk_ring[trk_pos] = gap;
      trk_pos = (trk_pos + 1) % WINDOW;
      if (trk_fill < WINDOW) trk_fill++;

      q = (64'(trk_sum) << 8) / 64'(trk_fill);
      trk_pulse = (q > 64'hFF_FFFF) ? 24'hFF_FFFF : q[PULSE_W-1:0];

      // A zero sum can only come from zero gaps; the tempo saturates.
      if (trk_sum == 0) begin
         raw = TEMPO_MAX;
      end else begin
         q = (64'(TEMPO_NUM) * 64'(trk_fill)) / 64'(trk_sum);
         raw = (q > 64'(TEMPO_MAX)) ? TEMPO_MAX : q[TEMPO_W-1:0];
      end

      // Smoothing: jump on a large difference, else count a trend.
      next_tempo = trk_smooth;
      diff = int'({9'd0, raw}) - int'({9'd0, trk_smooth});
      absdiff = (diff < 0) ? -diff : diff;
      if (absdiff > cfg_jump) begin
         next_tempo = raw;
         trk_jitter = 0;
      end else if (diff > 0) begin
         trk_jitter++;
         if (trk_jitter > int'(cfg_trend)) next_tempo = next_tempo + 1'b1;
      end else if (diff < 0) begin
         trk_jitter--;
         if (trk_jitter < -int'(cfg_trend)) next_tempo = next_tempo - 1'b1;
      end else if (trk_jitter > 0) begin
         trk_jitter--;
      end else if (trk_jitter < 0) begin
         trk_jitter++;
      end
      if (next_tempo != trk_smooth) begin
         trk_smooth = next_tempo;
         trk_jitter = 0;
      end
      return raw;
   endfunction

   // Work out the report that one accepted input beat causes.
   function automatic tempo_report_type track_beat(logic restart, logic [31:0] stamp);
      tempo_report_type r;
      logic [31:0]      gap;
      r.raw = '0;
      if (restart) begin
         restart_tracker_state();
         r.status = ST_RESTART;
      end else begin
         if (!trk_have_last) begin
            r.status = ST_FIRST;
         end else if (stamp < trk_last_stamp) begin
            clear_gap_window();
            r.status = ST_REWIND;
         end else begin
            gap = stamp - trk_last_stamp;
            if (gap > {16'd0, cfg_max_gap}) begin
               clear_gap_window();
               r.status = ST_LONG;
            end else if (gap < {16'd0, cfg_min_gap}) begin
               clear_gap_window();
               r.status = ST_SHORT;
            end else begin
               r.raw = take_gap(gap[GAP_W-1:0]);
               r.status = ST_ACCEPT;
            end
         end
         trk_last_stamp = stamp;
         trk_have_last = 1'b1;
      end
      r.pulse = trk_pulse;
      r.smooth = trk_smooth;
      return r;
   endfunction

   function automatic void queue_beat(logic restart, logic [31:0] stamp);
      tick_beat_type b;
      b.restart = restart;
      b.stamp = stamp;
      beats_to_send.push_back(b);
      if (!restart) gen_stamp = stamp;
   endfunction

   // Mostly steady tick runs with jitter, mixed with pauses, bursts,
   // rewinds, restarts and stray stamps.
   function automatic void queue_random_beats(int count);
      int pick;
      int gap;
      int lo;
      int hi;
      repeat (count) begin
         if (run_left == 0) begin
            lo = int'(cfg_min_gap);
            hi = lo + 120;
            if (hi > int'(cfg_max_gap)) hi = int'(cfg_max_gap);
            if (hi < lo) hi = lo;
            base_gap = $urandom_range(lo, hi);
            run_left = $urandom_range(20, 80);
         end
         run_left--;
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            if ($urandom_range(0, 19) == 0) begin
               base_gap += ($urandom_range(0, 1) != 0) ? 1 : -1;
               if (base_gap < 0) base_gap = 0;
            end
            gap = base_gap;
            if ($urandom_range(0, 1) != 0) gap += int'($urandom_range(0, 4)) - 2;
            if (gap < 0) gap = 0;
            queue_beat(1'b0, gen_stamp + gap);
         end else if (pick < 78) begin
            queue_beat(1'b0, gen_stamp + $urandom_range(cfg_min_gap, cfg_max_gap));
         end else if (pick < 83) begin
            queue_beat(1'b0, gen_stamp + cfg_max_gap + 1 + $urandom_range(0, 300));
         end else if (pick < 88) begin
            if (cfg_min_gap > 0)
               queue_beat(1'b0, gen_stamp + $urandom_range(0, cfg_min_gap - 1));
            else
               queue_beat(1'b0, gen_stamp);
         end else if (pick < 92) begin
            queue_beat(1'b0, gen_stamp - $urandom_range(1, 2000));
         end else if (pick < 95) begin
            queue_beat(1'b1, $urandom);
            gen_stamp = $urandom;
         end else begin
            queue_beat(1'b0, $urandom);
         end
      end
   endfunction

   // Wait until every queued beat has gone out and every report has come back.
   task automatic wait_idle();
      do @(negedge clock);
      while (beats_to_send.size() != 0 || req_tvalid || reports_due.size() != 0);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_MAX_GAP: cfg_max_gap = value[GAP_W-1:0];
         CSR_MIN_GAP: cfg_min_gap = value[GAP_W-1:0];
         CSR_JUMP:    cfg_jump = value[JUMP_W-1:0];
         default:     cfg_trend = value[TREND_W-1:0];
      endcase
   endtask

   task automatic write_all_csrs(logic [CSR_W-1:0] max_gap, logic [CSR_W-1:0] min_gap,
                                 logic [CSR_W-1:0] jump, logic [CSR_W-1:0] trend);
      write_csr(CSR_MAX_GAP, max_gap);
      write_csr(CSR_MIN_GAP, min_gap);
      write_csr(CSR_JUMP, jump);
      write_csr(CSR_TREND, trend);
   endtask

   // Sender: hands out queued beats in bursts separated by random pauses,
   // and predicts the report of every beat as it is accepted.
   always @(posedge clock) begin : sender
      tick_beat_type nb;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            reports_due.push_back(track_beat(req_tuser, req_tdata));
         if (!req_tvalid || req_tready) begin
            if (pause_left > 0 || beats_to_send.size() == 0) begin
               if (pause_left > 0) pause_left--;
               req_tvalid <= 1'b0;
            end else begin
               nb = beats_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= nb.restart;
               req_tdata <= nb.stamp;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 7);
                  pause_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
      end
   end

   // Receiver: checks each report beat against the oldest prediction and
   // stalls in randomly chosen modes.
   always @(posedge clock) begin : receiver
      tempo_report_type want;
      tempo_report_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tdata[2:0]);
            got.pulse = rsp_tdata[26:3];
            got.raw = rsp_tdata[49:27];
            got.smooth = rsp_tdata[72:50];
            if (reports_due.size() == 0) begin
               $error("report beat with no prediction waiting: %h", rsp_tdata);
               failed = 1'b1;
            end else begin
               want = reports_due.pop_front();
               if (got.status != want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  failed = 1'b1;
               end
               if (got.pulse != want.pulse) begin
                  $error("pulse_width_q8: expected %0d, actual %0d", want.pulse, got.pulse);
                  failed = 1'b1;
               end
               if (got.raw != want.raw) begin
                  $error("raw_tempo_x10: expected %0d, actual %0d", want.raw, got.raw);
                  failed = 1'b1;
               end
               if (got.smooth != want.smooth) begin
                  $error("smooth_tempo_x10: expected %0d, actual %0d",
                         want.smooth, got.smooth);
                  failed = 1'b1;
               end
               if (rsp_tdata[79:73] != '0) begin
                  $error("pad: expected 0, actual %0h", rsp_tdata[79:73]);
                  failed = 1'b1;
               end
            end
         end
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(32, 256);
         end else begin
            mode_left--;
         end
         stall_phase = stall_phase + 1'b1;
         case (ready_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 1) != 0);
            2:       rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= (stall_phase < 3'd5);
         endcase
      end
   end

   // Main sequence: directed beats at the reset settings, then several
   // register settings each followed by random beats.
   initial begin : main_seq
      int lo_gap;
      reset_tracker_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed beats: zero stamp, boundaries of the gap limits,
      // rewind, long and short gaps, restart, and a gap that only a
      // full-width compare sees as long.
      queue_beat(1'b0, 32'd0);
      queue_beat(1'b0, 32'd20);
      queue_beat(1'b0, 32'd41);
      queue_beat(1'b0, 32'd61);
      queue_beat(1'b0, 32'd50);
      queue_beat(1'b0, 32'd551);
      queue_beat(1'b0, 32'd1051);
      queue_beat(1'b0, 32'd1056);
      queue_beat(1'b0, 32'd1060);
      queue_beat(1'b0, 32'd1060);
      queue_beat(1'b1, 32'hFFFF_FFFF);
      queue_beat(1'b0, 32'hFFFF_FFFF);
      queue_beat(1'b0, 32'd0);
      queue_beat(1'b0, 32'h0001_0014);
      queue_beat(1'b0, 32'h0001_0028);
      queue_beat(1'b1, 32'd0);
      wait_idle();

      // Widest gap limits with zero thresholds: zero gaps reach the
      // saturated tempo and every change jumps.
      write_all_csrs(16'hFFFF, 16'd0, 16'd0, 16'd0);
      queue_beat(1'b1, $urandom);
      queue_beat(1'b0, 32'd1000);
      queue_beat(1'b0, 32'd1000);
      queue_beat(1'b0, 32'd1000);
      queue_beat(1'b0, 32'd1000 + 32'd65535);
      queue_beat(1'b0, 32'd1000 + 32'd65536);
      queue_beat(1'b0, 32'd1000 + 32'd131072);
      queue_random_beats(150);
      wait_idle();

      // Reset values written back with junk in the unused upper bits.
      write_all_csrs(16'd500, 16'd5, 16'hA80A, 16'h5A18);
      queue_random_beats(175);
      wait_idle();
      queue_random_beats(175);
      wait_idle();

      // Only a gap of exactly one is accepted.
      write_all_csrs(16'd1, 16'd1, 16'd5, 16'd3);
      queue_random_beats(120);
      wait_idle();

      // Largest thresholds: smoothing almost never moves.
      write_all_csrs(16'd2000, 16'd10, 16'd1023, 16'd255);
      queue_random_beats(250);
      wait_idle();

      // Random settings, thresholds written with random upper bits.
      repeat (2) begin
         lo_gap = $urandom_range(1, 200);
         write_all_csrs(16'(lo_gap + $urandom_range(0, 2000)), 16'(lo_gap),
                        16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
         queue_random_beats(110);
         wait_idle();
      end

      // Minimum above maximum: no gap is accepted.
      write_all_csrs(16'd10, 16'd20, 16'd10, 16'd24);
      queue_random_beats(40);
      wait_idle();

      repeat (100) @(posedge clock);
      if (!failed) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
